// ----- src/framed_path_to_uri_list_unit_macros.svh -----
// Assertion macros shared by the RTL of the uri list unit
`ifndef FRAMED_PATH_TO_URI_LIST_UNIT_MACROS_SVH
`define FRAMED_PATH_TO_URI_LIST_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FPUL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpul assertion failed");

// Next-cycle implication, checked outside reset
`define FPUL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpul assertion failed");

`endif

// ----- src/fpul_pkg.sv -----
package fpul_pkg;

    localparam int RUN_MAX = 10;

    localparam logic [12:0] FILE_LIMIT_RESET      = 13'd4096;
    localparam logic [20:0] PATH_BYTE_LIMIT_RESET = 21'd1048576;

    localparam logic REG_FILE_LIMIT      = 1'b0;
    localparam logic REG_PATH_BYTE_LIMIT = 1'b1;

    localparam logic [1:0] ERR_MAGIC    = 2'd0;
    localparam logic [1:0] ERR_COUNT    = 2'd1;
    localparam logic [1:0] ERR_LENGTH   = 2'd2;
    localparam logic [1:0] ERR_RELATIVE = 2'd3;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] chars;
        logic [3:0]              len;
        logic                    done;
        logic                    err;
        logic [1:0]              code;
    } run_t;

endpackage

// ----- src/fpul_parser.sv -----
module fpul_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         in_byte,
    input  logic               frame_start,
    input  logic [12:0]        file_limit,
    input  logic [20:0]        path_byte_limit,
    output fpul_pkg::run_t     run
);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HEADER,
        PH_LEN,
        PH_PATH
    } phase_t;

    localparam logic [3:0][7:0] MAGIC  = {8'h44, 8'h44, 8'h42, 8'h4D};
    localparam logic [7:0][7:0] PREFIX = {8'h2F, 8'h2F, 8'h2F, 8'h3A,
                                          8'h65, 8'h6C, 8'h69, 8'h66};
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
    endfunction

    function automatic logic unreserved(input logic [7:0] c);
        unreserved = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                     (c >= 8'h30 && c <= 8'h39) || c == 8'h2F || c == 8'h2D ||
                     c == 8'h5F || c == 8'h2E || c == 8'h7E;
    endfunction

    phase_t      phase_reg, phase_e, phase_next;
    logic [2:0]  idx_reg, idx_e, idx_next;
    logic [31:0] acc_reg, acc_e, acc_next;
    logic [12:0] files_reg, files_e, files_next;
    logic [20:0] bytes_reg, bytes_e, bytes_next;
    logic        zero_reg, zero_e, zero_next;
    logic        magic_bad_reg, magic_bad_e, magic_bad_next;

    always_comb
    begin
        if (frame_start)
        begin
            phase_e     = PH_HEADER;
            idx_e       = 3'd0;
            acc_e       = 32'd0;
            files_e     = 13'd0;
            bytes_e     = 21'd0;
            zero_e      = 1'b0;
            magic_bad_e = 1'b0;
        end
        else
        begin
            phase_e     = phase_reg;
            idx_e       = idx_reg;
            acc_e       = acc_reg;
            files_e     = files_reg;
            bytes_e     = bytes_reg;
            zero_e      = zero_reg;
            magic_bad_e = magic_bad_reg;
        end

        phase_next     = phase_e;
        idx_next       = idx_e;
        acc_next       = acc_e;
        files_next     = files_e;
        bytes_next     = bytes_e;
        zero_next      = zero_e;
        magic_bad_next = magic_bad_e;
        run            = '0;

        unique case (phase_e)
            PH_HEADER:
            begin
                if (!idx_e[2])
                begin
                    if (in_byte != MAGIC[idx_e[1:0]])
                        magic_bad_next = 1'b1;
                end
                else
                    acc_next[{idx_e[1:0], 3'b000} +: 8] =
                        acc_e[{idx_e[1:0], 3'b000} +: 8] | in_byte;
                idx_next = 3'(idx_e + 3'd1);
                if (idx_e == 3'd7)
                begin
                    if (magic_bad_e)
                    begin
                        run.len    = 4'd1;
                        run.err    = 1'b1;
                        run.code   = fpul_pkg::ERR_MAGIC;
                        phase_next = PH_WAIT;
                    end
                    else if (acc_next == 32'd0 || acc_next > {19'd0, file_limit})
                    begin
                        run.len    = 4'd1;
                        run.err    = 1'b1;
                        run.code   = fpul_pkg::ERR_COUNT;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        files_next = acc_next[12:0];
                        phase_next = PH_LEN;
                        idx_next   = 3'd0;
                        acc_next   = 32'd0;
                    end
                end
            end
            PH_LEN:
            begin
                acc_next[{idx_e[1:0], 3'b000} +: 8] =
                    acc_e[{idx_e[1:0], 3'b000} +: 8] | in_byte;
                idx_next = {1'b0, 2'(idx_e[1:0] + 2'd1)};
                if (idx_e[1:0] == 2'd3)
                begin
                    if (acc_next == 32'd0 || acc_next > {11'd0, path_byte_limit})
                    begin
                        run.len    = 4'd1;
                        run.err    = 1'b1;
                        run.code   = fpul_pkg::ERR_LENGTH;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        bytes_next = acc_next[20:0];
                        phase_next = PH_PATH;
                        idx_next   = 3'd0;
                        zero_next  = 1'b0;
                    end
                    acc_next = 32'd0;
                end
            end
            PH_PATH:
            begin
                if (idx_e == 3'd0)
                begin
                    if (in_byte != CH_SLASH)
                    begin
                        run.len    = 4'd1;
                        run.err    = 1'b1;
                        run.code   = fpul_pkg::ERR_RELATIVE;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        run.chars[7:0] = PREFIX;
                        run.len        = 4'd8;
                        idx_next       = 3'd1;
                    end
                end
                else if (zero_e || in_byte == 8'd0)
                    zero_next = 1'b1;
                else if (unreserved(in_byte))
                begin
                    run.chars[0] = in_byte;
                    run.len      = 4'd1;
                end
                else
                begin
                    run.chars[0] = CH_PERCENT;
                    run.chars[1] = hex_char(in_byte[7:4]);
                    run.chars[2] = hex_char(in_byte[3:0]);
                    run.len      = 4'd3;
                end
                if (!run.err)
                begin
                    bytes_next = 21'(bytes_e - 21'd1);
                    if (bytes_next == 21'd0)
                    begin
                        files_next                 = 13'(files_e - 13'd1);
                        run.chars[run.len]         = fpul_pkg::CH_CR;
                        run.chars[4'(run.len + 1)] = fpul_pkg::CH_LF;
                        run.len                    = 4'(run.len + 4'd2);
                        run.done                   = (files_next == 13'd0);
                        phase_next = (files_next == 13'd0) ? PH_WAIT : PH_LEN;
                        idx_next   = 3'd0;
                        acc_next   = 32'd0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            idx_reg       <= 3'd0;
            acc_reg       <= 32'd0;
            files_reg     <= 13'd0;
            bytes_reg     <= 21'd0;
            zero_reg      <= 1'b0;
            magic_bad_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            acc_reg       <= acc_next;
            files_reg     <= files_next;
            bytes_reg     <= bytes_next;
            zero_reg      <= zero_next;
            magic_bad_reg <= magic_bad_next;
        end
    end

endmodule

// ----- src/framed_path_to_uri_list_unit.sv -----
// Framed path list to text/uri-list converter.
// Input stream: one byte of the framed stream per transaction; tuser marks the
// first byte of a new frame and abandons any unfinished one. Output stream: one
// uri-list character per transaction; tlast closes the characters caused by one
// input byte, tuser carries list done, error flag and error code. An error
// result carries a zero byte; the receiver drops the frame's earlier output.
// Configuration: cfg_we with cfg_index 0 writes the path count limit, 1 writes
// the path byte limit; write only while the unit is idle.
// Data path: a byte is taken into the input register, then parsed combinationally
// into the character run register, which presents its first character. Each
// input byte yields one to ten characters (three for an encoded byte, plus CR
// LF at a path's end), or none. The output side drains the run register one
// character per cycle while the receiver is ready, while the input register
// already holds the next byte.
// Reset: both channels empty, parser waiting for a frame start, limits at
// 4096 paths and 1048576 bytes. When the receiver stalls, the current
// character holds, one further byte is taken into the input register, and
// tready then stays low.
`include "framed_path_to_uri_list_unit_macros.svh"

module framed_path_to_uri_list_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic [3:0]  m_axis_tuser,   // [0] list_done, [1] error_flag, [3:2] error_code
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [20:0] cfg_data
);

    logic [12:0]     file_limit_reg;
    logic [20:0]     path_byte_limit_reg;
    logic            hold_valid_reg;
    logic [7:0]      hold_byte_reg;
    logic            hold_start_reg;
    fpul_pkg::run_t  run_reg;
    fpul_pkg::run_t  run_new;
    logic            run_valid_reg;
    logic [3:0]      pos_reg;
    logic            at_last;
    logic            can_load;
    logic            load;

    assign at_last       = (pos_reg == 4'(run_reg.len - 4'd1));
    assign can_load      = !run_valid_reg || (m_axis_tready && at_last);
    assign load          = hold_valid_reg && can_load;
    assign s_axis_tready = !hold_valid_reg || can_load;

    assign m_axis_tvalid = run_valid_reg;
    assign m_axis_tdata  = run_reg.chars[pos_reg];
    assign m_axis_tlast  = at_last;
    assign m_axis_tuser  = {run_reg.code, run_reg.err, run_reg.done && at_last};

    fpul_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (load),
        .in_byte         (hold_byte_reg),
        .frame_start     (hold_start_reg),
        .file_limit      (file_limit_reg),
        .path_byte_limit (path_byte_limit_reg),
        .run             (run_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_limit_reg      <= fpul_pkg::FILE_LIMIT_RESET;
            path_byte_limit_reg <= fpul_pkg::PATH_BYTE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fpul_pkg::REG_FILE_LIMIT:      file_limit_reg      <= cfg_data[12:0];
                fpul_pkg::REG_PATH_BYTE_LIMIT: path_byte_limit_reg <= cfg_data;
                default:                       file_limit_reg      <= file_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            hold_valid_reg <= 1'b1;
        else if (load)
            hold_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            hold_byte_reg  <= s_axis_tdata;
            hold_start_reg <= s_axis_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            pos_reg       <= 4'd0;
        end
        else if (load)
        begin
            run_valid_reg <= (run_new.len != 4'd0);
            pos_reg       <= 4'd0;
        end
        else if (run_valid_reg && m_axis_tready)
        begin
            if (at_last)
                run_valid_reg <= 1'b0;
            pos_reg <= 4'(pos_reg + 4'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            run_reg <= run_new;
    end

    `FPUL_ASSERT_NOW(a_run_in_range, clk, rst_n, run_valid_reg,
        run_reg.len != 4'd0 && pos_reg < run_reg.len)
    `FPUL_ASSERT_NOW(a_error_single, clk, rst_n, run_valid_reg && run_reg.err,
        run_reg.len == 4'd1 && m_axis_tdata == 8'd0)
    `FPUL_ASSERT_NOW(a_done_on_lf, clk, rst_n, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tdata == fpul_pkg::CH_LF && m_axis_tlast)
    `FPUL_ASSERT_NEXT(a_hold_kept, clk, rst_n, hold_valid_reg && !load, hold_valid_reg)

endmodule
